// ===== rtl/rirk3_pkg.sv =====
// Shared types, constants and arithmetic helpers for the implicit RK3 integrator.
package rirk3_pkg;

  localparam int FRAC_BITS = 40;
  localparam int STAGES = 3;
  localparam int SLOPE_W = $clog2(2 * STAGES);

  localparam logic signed [63:0] Q_ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] Q_THIRD = ((64'sd1 <<< FRAC_BITS) + 64'sd1) / 64'sd3;
  localparam logic signed [63:0] Q_3QTR = ((64'sd1 <<< FRAC_BITS) / 64'sd4) * 64'sd3;
  localparam logic signed [63:0] Q_TWELFTH = ((64'sd1 <<< FRAC_BITS) + 64'sd6) / 64'sd12;
  localparam logic [62:0] TIME_MAX = {63{1'b1}};
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  localparam logic [2:0] CFG_GAIN = 3'd0;
  localparam logic [2:0] CFG_STEP = 3'd1;
  localparam logic [2:0] CFG_INIT_POS = 3'd2;
  localparam logic [2:0] CFG_INIT_VEL = 3'd3;
  localparam logic [2:0] CFG_SWEEPS = 3'd4;

  // Multiplier operand selects.
  typedef enum logic [2:0] {
    SRC_T,
    SRC_K,
    SRC_GAIN,
    SRC_STEP,
    SRC_ACC_V,
    SRC_COEF
  } msrc_t;

  // Destinations for a multiplier result.
  typedef enum logic [3:0] {
    DST_NONE,
    DST_VV,
    DST_TV,
    DST_MU,
    DST_HCOEF,
    DST_SY,
    DST_SV,
    DST_NY,
    DST_NV
  } mdst_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_COEF,
    ST_ACC_VV,
    ST_ACC_TV,
    ST_ACC_MU,
    ST_ACC_FIN,
    ST_SEED,
    ST_SWEEP_INIT,
    ST_SWEEP_MAC_Y,
    ST_SWEEP_MAC_V,
    ST_SWEEP_WRITE,
    ST_FINAL_MAC_Y,
    ST_FINAL_MAC_V,
    ST_COMMIT,
    ST_RELOAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        reload;
    logic        acc_from_base;
    logic        acc_from_stage;
    logic        acc_fin;
    logic        seed;
    logic        stage_init;
    logic        stage_write;
    logic        final_init;
    logic        commit;
    logic        mul_go;
    msrc_t       srca;
    msrc_t       srcb;
    logic [1:0]  shift_sel;
    mdst_t       dst;
    logic [1:0]  j;
    logic [1:0]  k;
    logic        coef_d;
  } dp_cmd_t;

  typedef struct packed {
    logic       mul_done;
  } dp_sts_t;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_neg(logic signed [63:0] a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  function automatic logic signed [63:0] a_coef(logic [1:0] j, logic [1:0] k);
    logic signed [63:0] r;
    r = 64'sd0;
    case ({j, k})
      4'b0000: r = Q_THIRD;
      4'b0101: r = Q_ONE;
      4'b1000: r = Q_3QTR;
      4'b1001: r = -Q_TWELFTH;
      4'b1010: r = Q_THIRD;
      default: r = 64'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] d_coef(logic [1:0] k);
    logic signed [63:0] r;
    case (k)
      2'd0: r = Q_3QTR;
      2'd1: r = -Q_TWELFTH;
      2'd2: r = Q_THIRD;
      default: r = 64'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/rirk3_if.sv =====
// Valid-ready channel interfaces for the integrator input and result.
interface rirk3_in_if (input logic clk);
  logic valid;
  logic ready;
  logic reload;
  modport source (output valid, output reload, input ready);
  modport sink (input valid, input reload, output ready);
endinterface

interface rirk3_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [62:0] time_now;
  logic [63:0] position_out;
  logic [63:0] velocity_out;
  modport source (output valid, output time_now, output position_out, output velocity_out,
                  input ready);
  modport sink (input valid, input time_now, input position_out, input velocity_out,
                output ready);
endinterface

// ===== rtl/rirk3_mul.sv =====
// Sequential signed 64x64 multiplier built from 32x32 partial products, shift and saturate.
module rirk3_mul import rirk3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic               int_mode,
  output logic               done,
  output logic signed [63:0] res
);

  logic        neg_r, neg_nxt;
  logic [63:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        int_r, int_nxt;
  logic        done_r, done_nxt;
  logic signed [63:0] res_r, res_nxt;
  logic [31:0] xa, xb;
  logic [63:0] pp;
  logic [127:0] pps;
  logic [127:0] sh;
  logic        ovf;
  logic [63:0] mag;

  always_comb begin
    xa = cnt_r[0] ? ma_r[63:32] : ma_r[31:0];
    xb = cnt_r[1] ? mb_r[63:32] : mb_r[31:0];
    pp = 64'(xa) * 64'(xb);
    pps = 128'(pp) << (32 * (32'(cnt_r[0]) + 32'(cnt_r[1])));
  end

  always_comb begin
    sh = int_r ? acc_r : (acc_r >> FRAC_BITS);
    ovf = sh[127:64] != 64'd0;
    mag = sh[63:0];
  end

  always_comb begin
    neg_nxt = neg_r;
    ma_nxt = ma_r;
    mb_nxt = mb_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    int_nxt = int_r;
    done_nxt = 1'b0;
    res_nxt = res_r;
    if (go) begin
      neg_nxt = a[63] != b[63];
      ma_nxt = a[63] ? 64'(-a) : 64'(a);
      mb_nxt = b[63] ? 64'(-b) : 64'(b);
      acc_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
      int_nxt = int_mode;
    end else if (busy_r) begin
      if (cnt_r == 3'd4) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (neg_r) begin
          res_nxt = (ovf || mag >= 64'h8000_0000_0000_0000) ? S64_MIN : -$signed(mag);
        end else begin
          res_nxt = (ovf || mag[63]) ? S64_MAX : $signed(mag);
        end
      end else begin
        acc_nxt = acc_r + pps;
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
    acc_r <= acc_nxt;
    int_r <= int_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res = res_r;

endmodule

// ===== rtl/rirk3_datapath.sv =====
// Datapath: state, configuration, stage slopes, coefficient products and accumulators.
module rirk3_datapath import rirk3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  output logic [3:0]  sweeps,
  output logic [62:0] time_now,
  output logic [63:0] position_out,
  output logic [63:0] velocity_out
);

  logic [15:0] gain_r;
  logic [39:0] step_r;
  logic signed [63:0] ipos_r, ivel_r;
  logic [3:0] sweeps_r;
  logic [62:0] time_r, time_nxt;
  logic signed [63:0] pos_r, vel_r;
  logic signed [63:0] k_r [2 * STAGES];
  logic signed [63:0] ha_r [STAGES * STAGES];
  logic signed [63:0] hd_r [STAGES];
  logic signed [63:0] ay_r, av_r, t_r, sy_r, sv_r;
  logic signed [63:0] ma, mb, mres;
  logic mdone;
  logic [63:0] tsum;

  always_comb begin
    case (cmd.srca)
      SRC_T: ma = t_r;
      SRC_STEP: ma = 64'(step_r);
      SRC_ACC_V: ma = av_r;
      SRC_COEF: ma = cmd.coef_d ? hd_r[cmd.k] : ha_r[4'(cmd.j) * 4'd3 + 4'(cmd.k)];
      default: ma = t_r;
    endcase
    case (cmd.srcb)
      SRC_K: mb = k_r[SLOPE_W'(cmd.shift_sel[0]) * SLOPE_W'(3) + SLOPE_W'(cmd.k)];
      SRC_GAIN: mb = 64'(gain_r);
      SRC_ACC_V: mb = av_r;
      SRC_COEF: mb = cmd.coef_d ? d_coef(cmd.k) : a_coef(cmd.j, cmd.k);
      default: mb = av_r;
    endcase
  end

  rirk3_mul u_mul (
    .clk(clk), .rst_n(rst_n), .go(cmd.mul_go), .a(ma), .b(mb),
    .int_mode(cmd.shift_sel[1]), .done(mdone), .res(mres)
  );

  assign sts.mul_done = mdone;

  always_comb begin
    tsum = {1'b0, time_r} + 64'(step_r);
    time_nxt = tsum[63] ? TIME_MAX : tsum[62:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= 16'd1000;
      step_r <= 40'd109952262;
      ipos_r <= '0;
      ivel_r <= Q_ONE;
      sweeps_r <= 4'd10;
      time_r <= '0;
      pos_r <= '0;
      vel_r <= Q_ONE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN: gain_r <= cfg_data[15:0];
          CFG_STEP: step_r <= cfg_data[39:0];
          CFG_INIT_POS: ipos_r <= cfg_data;
          CFG_INIT_VEL: ivel_r <= cfg_data;
          CFG_SWEEPS: sweeps_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.reload) begin
        time_r <= '0;
        pos_r <= ipos_r;
        vel_r <= ivel_r;
      end else if (cmd.commit) begin
        time_r <= time_nxt;
        pos_r <= sy_r;
        vel_r <= sv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_from_base) begin
      ay_r <= pos_r;
      av_r <= vel_r;
    end else if (cmd.acc_from_stage) begin
      // The last velocity term lands in the same cycle.
      ay_r <= sy_r;
      av_r <= sat_add(sv_r, mres);
    end
    if (cmd.stage_init || cmd.final_init) begin
      sy_r <= pos_r;
      sv_r <= vel_r;
    end
    if (cmd.acc_fin) t_r <= sat_add(t_r, sat_neg(ay_r));
    if (mdone) begin
      case (cmd.dst)
        DST_VV: t_r <= sat_add(Q_ONE, sat_neg(mres));
        DST_TV: t_r <= mres;
        DST_MU: t_r <= mres;
        DST_HCOEF: begin
          if (cmd.coef_d) hd_r[cmd.k] <= mres;
          else ha_r[4'(cmd.j) * 4'd3 + 4'(cmd.k)] <= mres;
        end
        DST_SY, DST_NY: sy_r <= sat_add(sy_r, mres);
        DST_SV, DST_NV: sv_r <= sat_add(sv_r, mres);
        default: ;
      endcase
    end
    if (cmd.seed) begin
      for (int i = 0; i < STAGES; i++) begin
        k_r[i] <= vel_r;
        k_r[STAGES + i] <= t_r;
      end
    end
    if (cmd.stage_write) begin
      k_r[SLOPE_W'(cmd.j)] <= sv_r;
      k_r[SLOPE_W'(cmd.j) + SLOPE_W'(STAGES)] <= t_r;
    end
  end

  assign sweeps = sweeps_r;
  assign time_now = time_r;
  assign position_out = pos_r;
  assign velocity_out = vel_r;

endmodule

// ===== rtl/rirk3_ctrl.sv =====
// Controller state machine sequencing coefficients, sweeps and the final update.
module rirk3_ctrl import rirk3_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_reload,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  logic [3:0] sweeps,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic [1:0] j_r, j_nxt, k_r, k_nxt;
  logic [3:0] s_r, s_nxt;
  logic issued_r, issued_nxt;
  logic coefd_r, coefd_nxt;
  state_t ret_r, ret_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    j_nxt = j_r;
    k_nxt = k_r;
    s_nxt = s_r;
    issued_nxt = issued_r;
    coefd_nxt = coefd_r;
    ret_nxt = ret_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_reload) state_nxt = ST_RELOAD;
          else begin
            state_nxt = ST_COEF;
            j_nxt = '0;
            k_nxt = '0;
            coefd_nxt = 1'b0;
            issued_nxt = 1'b0;
          end
        end
      end
      ST_COEF: begin
        if (!issued_r) issued_nxt = 1'b1;
        else if (sts.mul_done) begin
          issued_nxt = 1'b0;
          if (k_r != 2'd2) k_nxt = k_r + 2'd1;
          else begin
            k_nxt = '0;
            if (coefd_r) begin
              state_nxt = ST_ACC_VV;
              ret_nxt = ST_SEED;
            end else if (j_r != 2'd2) j_nxt = j_r + 2'd1;
            else coefd_nxt = 1'b1;
          end
        end
      end
      ST_ACC_VV, ST_ACC_TV, ST_ACC_MU: begin
        if (!issued_r) issued_nxt = 1'b1;
        else if (sts.mul_done) begin
          issued_nxt = 1'b0;
          case (state_r)
            ST_ACC_VV: state_nxt = ST_ACC_TV;
            ST_ACC_TV: state_nxt = ST_ACC_MU;
            default: state_nxt = ST_ACC_FIN;
          endcase
        end
      end
      ST_ACC_FIN: state_nxt = ret_r;
      ST_SEED: begin
        j_nxt = '0;
        s_nxt = '0;
        state_nxt = (sweeps == 4'd0) ? ST_FINAL_MAC_Y : ST_SWEEP_INIT;
        k_nxt = '0;
      end
      ST_SWEEP_INIT: begin
        k_nxt = '0;
        state_nxt = ST_SWEEP_MAC_Y;
      end
      ST_SWEEP_MAC_Y, ST_FINAL_MAC_Y: begin
        if (!issued_r) issued_nxt = 1'b1;
        else if (sts.mul_done) begin
          issued_nxt = 1'b0;
          state_nxt = (state_r == ST_SWEEP_MAC_Y) ? ST_SWEEP_MAC_V : ST_FINAL_MAC_V;
        end
      end
      ST_SWEEP_MAC_V: begin
        if (!issued_r) issued_nxt = 1'b1;
        else if (sts.mul_done) begin
          issued_nxt = 1'b0;
          if (k_r != 2'd2) begin
            k_nxt = k_r + 2'd1;
            state_nxt = ST_SWEEP_MAC_Y;
          end else begin
            state_nxt = ST_ACC_VV;
            ret_nxt = ST_SWEEP_WRITE;
          end
        end
      end
      ST_SWEEP_WRITE: begin
        if (j_r != 2'd2) begin
          j_nxt = j_r + 2'd1;
          state_nxt = ST_SWEEP_INIT;
        end else begin
          j_nxt = '0;
          if (s_r + 4'd1 == sweeps) begin
            k_nxt = '0;
            state_nxt = ST_FINAL_MAC_Y;
          end else begin
            s_nxt = s_r + 4'd1;
            state_nxt = ST_SWEEP_INIT;
          end
        end
      end
      ST_FINAL_MAC_V: begin
        if (!issued_r) issued_nxt = 1'b1;
        else if (sts.mul_done) begin
          issued_nxt = 1'b0;
          if (k_r != 2'd2) begin
            k_nxt = k_r + 2'd1;
            state_nxt = ST_FINAL_MAC_Y;
          end else state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT, ST_RELOAD: state_nxt = ST_OUT;
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    cmd.j = j_r;
    cmd.k = k_r;
    cmd.coef_d = coefd_r;
    cmd.srca = SRC_T;
    cmd.srcb = SRC_ACC_V;
    cmd.dst = DST_NONE;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.acc_from_base = in_valid && !in_reload;
      end
      ST_COEF: begin
        cmd.mul_go = !issued_r;
        cmd.srca = SRC_STEP;
        cmd.srcb = SRC_COEF;
        cmd.dst = DST_HCOEF;
      end
      ST_ACC_VV: begin
        cmd.mul_go = !issued_r;
        cmd.srca = SRC_ACC_V;
        cmd.srcb = SRC_ACC_V;
        cmd.dst = DST_VV;
      end
      ST_ACC_TV: begin
        cmd.mul_go = !issued_r;
        cmd.srca = SRC_T;
        cmd.srcb = SRC_ACC_V;
        cmd.dst = DST_TV;
      end
      ST_ACC_MU: begin
        cmd.mul_go = !issued_r;
        cmd.srca = SRC_T;
        cmd.srcb = SRC_GAIN;
        cmd.shift_sel = 2'b10;
        cmd.dst = DST_MU;
      end
      ST_ACC_FIN: cmd.acc_fin = 1'b1;
      ST_SEED: cmd.seed = 1'b1;
      ST_SWEEP_INIT: cmd.stage_init = 1'b1;
      ST_SWEEP_MAC_Y, ST_SWEEP_MAC_V, ST_FINAL_MAC_Y, ST_FINAL_MAC_V: begin
        cmd.mul_go = !issued_r;
        cmd.srca = SRC_COEF;
        cmd.srcb = SRC_K;
        cmd.coef_d = (state_r == ST_FINAL_MAC_Y) || (state_r == ST_FINAL_MAC_V);
        cmd.shift_sel = {1'b0,
          (state_r == ST_SWEEP_MAC_V) || (state_r == ST_FINAL_MAC_V)};
        case (state_r)
          ST_SWEEP_MAC_Y: cmd.dst = DST_SY;
          ST_SWEEP_MAC_V: cmd.dst = DST_SV;
          ST_FINAL_MAC_Y: cmd.dst = DST_NY;
          default: cmd.dst = DST_NV;
        endcase
        cmd.acc_from_stage = (state_r == ST_SWEEP_MAC_V) && sts.mul_done && (k_r == 2'd2);
      end
      ST_SWEEP_WRITE: cmd.stage_write = 1'b1;
      ST_COMMIT: cmd.commit = 1'b1;
      ST_RELOAD: cmd.reload = 1'b1;
      ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
    if (state_r == ST_SEED && sweeps == 4'd0) cmd.final_init = 1'b1;
    if (state_r == ST_SWEEP_WRITE && j_r == 2'd2 && s_r + 4'd1 == sweeps) cmd.final_init = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      issued_r <= 1'b0;
      j_r <= '0;
      k_r <= '0;
      s_r <= '0;
      coefd_r <= 1'b0;
      ret_r <= ST_SEED;
    end else begin
      state_r <= state_nxt;
      issued_r <= issued_nxt;
      j_r <= j_nxt;
      k_r <= k_nxt;
      s_r <= s_nxt;
      coefd_r <= coefd_nxt;
      ret_r <= ret_nxt;
    end
  end

endmodule

// ===== rtl/rayleigh_implicit_rk3_step.sv =====
// A reload goes from its transfer through the reload state to its result; an advance is
// computed on one shared 64x64 multiplier, which works on one product at a time.
// Throughput: one item at a time; the next transfer is taken after the result leaves.
// Reset (synchronous, active low) loads the default registers, time zero,
// position zero and velocity one.
module rayleigh_implicit_rk3_step import rirk3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rirk3_in_if.sink    in_ch,
  rirk3_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [3:0] sweeps;

  rirk3_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_reload(in_ch.reload),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sweeps(sweeps), .sts(sts), .cmd(cmd)
  );

  rirk3_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .sweeps(sweeps), .time_now(out_ch.time_now),
    .position_out(out_ch.position_out), .velocity_out(out_ch.velocity_out)
  );

endmodule

// ===== rtl/rirk3_checker.sv =====
// Port-level checker for the integrator, bound to the top level.
module rirk3_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [62:0] time_now
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while a result waits");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(time_now)) else $error("result dropped");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second transfer accepted while busy");

endmodule

bind rayleigh_implicit_rk3_step rirk3_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .time_now(out_ch.time_now)
);

// ===== verif/rayleigh_implicit_rk3_step_test.sv =====
// Self-checking test of the implicit RK3 Rayleigh integrator with randomized flow control.
module rayleigh_implicit_rk3_step_test;
  import rirk3_pkg::*;

  typedef struct packed {
    logic [62:0] time_now;
    logic [63:0] position_out;
    logic [63:0] velocity_out;
  } point_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  rirk3_in_if in_ch (clk);
  rirk3_out_if out_ch (clk);

  rayleigh_implicit_rk3_step dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [15:0] gain_m;
  logic [39:0] step_m;
  logic signed [63:0] init_pos_m;
  logic signed [63:0] init_vel_m;
  logic [3:0] sweeps_m;
  logic [62:0] time_m;
  logic signed [63:0] pos_m;
  logic signed [63:0] vel_m;

  point_t expected_points[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  int out_wait = 0;
  bit random_ready = 1'b1;

  localparam int WATCHDOG = 40000;
  localparam int HOLD_CYCLES = 2000;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Exact product shifted right with truncation toward zero, saturated.
  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b,
                                                 int shift);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [127:0] p;
    logic [127:0] mag;
    logic neg;
    neg = a[63] ^ b[63];
    ma = a[63] ? 64'(-a) : 64'(a);
    mb = b[63] ? 64'(-b) : 64'(b);
    p = 128'(ma) * 128'(mb);
    mag = p >> shift;
    if (neg) begin
      if (mag >= (128'd1 << 63)) return S64_MIN;
      return -$signed(mag[63:0]);
    end
    if (mag > 128'(S64_MAX)) return S64_MAX;
    return mag[63:0];
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] neg_sat(logic signed [63:0] a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  function automatic logic signed [63:0] rayleigh_accel(logic signed [63:0] y,
                                                        logic signed [63:0] v);
    logic signed [63:0] t;
    t = add_sat(Q_ONE, neg_sat(fx_mul(v, v, FRAC_BITS)));
    t = fx_mul(t, v, FRAC_BITS);
    t = fx_mul(t, {48'd0, gain_m}, 0);
    return add_sat(t, neg_sat(y));
  endfunction

  function automatic point_t integrate(logic reload);
    logic signed [63:0] butcher_a[3][3];
    logic signed [63:0] weights[3];
    logic signed [63:0] ha[3][3];
    logic signed [63:0] hd[3];
    logic signed [63:0] ky[3];
    logic signed [63:0] kv[3];
    logic signed [63:0] h, sy, sv, ny, nv, seed_v;
    logic [63:0] t_sum;
    point_t p;
    butcher_a = '{'{Q_THIRD, 0, 0}, '{0, Q_ONE, 0}, '{Q_3QTR, -Q_TWELFTH, Q_THIRD}};
    weights = '{Q_3QTR, -Q_TWELFTH, Q_THIRD};
    if (reload) begin
      time_m = '0;
      pos_m = init_pos_m;
      vel_m = init_vel_m;
    end else begin
      h = {24'd0, step_m};
      seed_v = rayleigh_accel(pos_m, vel_m);
      for (int j = 0; j < 3; j++) begin
        ky[j] = vel_m;
        kv[j] = seed_v;
        hd[j] = fx_mul(h, weights[j], FRAC_BITS);
        for (int k = 0; k < 3; k++) ha[j][k] = fx_mul(h, butcher_a[j][k], FRAC_BITS);
      end
      for (int s = 0; s < sweeps_m; s++) begin
        for (int j = 0; j < 3; j++) begin
          sy = pos_m;
          sv = vel_m;
          for (int k = 0; k < 3; k++) begin
            sy = add_sat(sy, fx_mul(ha[j][k], ky[k], FRAC_BITS));
            sv = add_sat(sv, fx_mul(ha[j][k], kv[k], FRAC_BITS));
          end
          ky[j] = sv;
          kv[j] = rayleigh_accel(sy, sv);
        end
      end
      ny = pos_m;
      nv = vel_m;
      for (int j = 0; j < 3; j++) begin
        ny = add_sat(ny, fx_mul(hd[j], ky[j], FRAC_BITS));
        nv = add_sat(nv, fx_mul(hd[j], kv[j], FRAC_BITS));
      end
      pos_m = ny;
      vel_m = nv;
      t_sum = {1'b0, time_m} + {24'd0, step_m};
      time_m = t_sum[63] ? TIME_MAX : t_sum[62:0];
    end
    p.time_now = time_m;
    p.position_out = pos_m;
    p.velocity_out = vel_m;
    return p;
  endfunction

  task automatic send_item(logic reload, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    repeat (gap) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.reload = reload;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_points.push_back(integrate(reload));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(logic [2:0] index, logic [63:0] value);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (index)
      CFG_GAIN: gain_m = value[15:0];
      CFG_STEP: step_m = value[39:0];
      CFG_INIT_POS: init_pos_m = value;
      CFG_INIT_VEL: init_vel_m = value;
      CFG_SWEEPS: sweeps_m = value[3:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (expected_points.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < 4; i++) send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    drain();
  endtask

  task automatic test_extremes();
    logic [63:0] vals[5];
    vals = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 0, 64'hFFFF_FFFF_FFFF_FFFF,
             64'h0000_0100_0000_0000};
    write_reg(CFG_SWEEPS, 4'd1);
    write_reg(CFG_STEP, 40'hFF_FFFF_FFFF);
    write_reg(CFG_GAIN, 16'hFFFF);
    foreach (vals[i]) begin
      write_reg(CFG_INIT_POS, vals[i]);
      write_reg(CFG_INIT_VEL, vals[(i + 2) % 5]);
      send_item(1'b1, 1'b0);
      send_item(1'b0, 1'b0);
      send_item(1'b0, 1'b0);
      drain();
    end
    write_reg(CFG_GAIN, 0);
    write_reg(CFG_STEP, 0);
    write_reg(CFG_SWEEPS, 4'd15);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    drain();
  endtask

  task automatic test_time_saturation();
    write_reg(CFG_STEP, 40'hFF_FFFF_FFFF);
    write_reg(CFG_SWEEPS, 4'd1);
    write_reg(CFG_GAIN, 0);
    write_reg(CFG_INIT_POS, 0);
    write_reg(CFG_INIT_VEL, 0);
    // Time only saturates after 2^23 steps, so it is checked by the predictor alone here.
    send_item(1'b1, 1'b0);
    for (int i = 0; i < 3; i++) send_item(1'b0, 1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(CFG_SWEEPS, 4'd1);
    random_ready = 1'b0;
    hold_off = 1;
    for (int i = 0; i < 4; i++) send_item(i[0], 1'b1);
    drain();
  endtask

  task automatic test_random_runs();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_GAIN, (phase % 3 == 0) ? $urandom_range(0, 20) : $urandom_range(0, 65535));
      write_reg(CFG_STEP, (phase % 2) ? {8'd0, 32'($urandom)} : {8'($urandom), 32'($urandom)});
      write_reg(CFG_INIT_POS, {$urandom, $urandom});
      write_reg(CFG_INIT_VEL, (phase % 2) ? 64'($signed($urandom_range(0, 8192)) <<< 28)
                                           : {$urandom, $urandom});
      write_reg(CFG_SWEEPS, (phase == 5) ? 4'd15 : 4'($urandom_range(1, 3)));
      for (int i = 0; i < ((phase == 5) ? 50 : 250); i++)
        send_item($urandom_range(0, 15) == 0, $urandom_range(0, 3) == 0);
      drain();
    end
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= (hold_off == HOLD_CYCLES) ? 0 : hold_off + 1;
      if (hold_off == HOLD_CYCLES) random_ready = 1'b1;
    end else if (random_ready && out_wait > 0) begin
      out_ch.ready <= 1'b0;
      out_wait <= out_wait - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      out_wait <= $urandom_range(0, 19);
      if (expected_points.size() == 0) begin
        $error("Result transfer with no expected point");
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (out_ch.time_now !== want.time_now) begin
          $error("time_now: expected %h, actual %h", want.time_now, out_ch.time_now);
          errors++;
        end
        if (out_ch.position_out !== want.position_out) begin
          $error("position_out: expected %h, actual %h", want.position_out,
                 out_ch.position_out);
          errors++;
        end
        if (out_ch.velocity_out !== want.velocity_out) begin
          $error("velocity_out: expected %h, actual %h", want.velocity_out,
                 out_ch.velocity_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.reload = 1'b0;
    out_ch.ready = 1'b0;
    gain_m = 16'd1000;
    step_m = 40'd109952262;
    init_pos_m = 0;
    init_vel_m = Q_ONE;
    sweeps_m = 4'd10;
    time_m = '0;
    pos_m = 0;
    vel_m = Q_ONE;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_extremes();
    test_time_saturation();
    test_backpressure();
    test_random_runs();
    repeat (20) @(negedge clk);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== rayleigh_implicit_rk3_step.f =====
rtl/rirk3_pkg.sv
rtl/rirk3_if.sv
rtl/rirk3_mul.sv
rtl/rirk3_datapath.sv
rtl/rirk3_ctrl.sv
rtl/rayleigh_implicit_rk3_step.sv
rtl/rirk3_checker.sv
verif/rayleigh_implicit_rk3_step_test.sv
